[rtl/core/dea_pkg.sv]
// shared types and constants for the double-ended arena allocator
`timescale 1ns / 1ps

package dea_pkg;

  localparam int ADDR_W = 24;
  localparam int NEED_W = ADDR_W + 1;
  localparam int SUM_W = ADDR_W + 2;
  localparam int HEADER_BYTES = 16;
  localparam int ROUND_BYTES = 15;
  localparam logic [ADDR_W-1:0] ARENA_RESET = ADDR_W'(8388608);

  // request codes
  localparam logic [2:0] REQ_ALLOC_LOW = 3'd0;
  localparam logic [2:0] REQ_ALLOC_HIGH = 3'd1;
  localparam logic [2:0] REQ_TEMP_ALLOC = 3'd2;
  localparam logic [2:0] REQ_FREE_LOW = 3'd3;
  localparam logic [2:0] REQ_FREE_HIGH = 3'd4;
  localparam logic [2:0] REQ_READ_LOW = 3'd5;
  localparam logic [2:0] REQ_READ_HIGH = 3'd6;

  // result status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_MARK = 2'd2;

  typedef struct packed {
    logic load;
    logic rel;
    logic check;
    logic commit;
  } dea_cmd_t;

  typedef struct packed {
    logic alloc;
  } dea_stat_t;

endpackage

[rtl/core/double_ended_arena_allocator.sv]
// top level of the double-ended arena allocator
// usage:
//   two bump counters share one arena of arena_size bytes; the low end
//   grows up from offset 0, the high end grows down from arena_size
//   request channel: in_valid / in_stall carry one word (req_type,
//   req_size, req_mark); a word is taken when in_valid is high and
//   in_stall is low
//   result channel: out_valid / out_stall carry one word per request
//   (status, address, low_mark, high_mark, temp_live)
//   config: cfg_we writes cfg_data into arena_size; the user must write
//   only while idle, as the block itself does not enforce it
//   timing: a request walks load, temp release, fit check, commit;
//   frees and reads skip the fit check; the controller steps one request
//   at a time through the counters and takes no new one until it commits
//   stall: the result sits in an output register; a new request is taken
//   while it waits, but the next commit holds until the result is taken
//   reset (rst, synchronous): counters and temp flag clear, arena_size
//   returns to 8 MiB, no result is pending
`timescale 1ns / 1ps

module double_ended_arena_allocator import dea_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        req_type,
  input  logic [ADDR_W-1:0] req_size,
  input  logic [ADDR_W-1:0] req_mark,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [ADDR_W-1:0] address,
  output logic [ADDR_W-1:0] low_mark,
  output logic [ADDR_W-1:0] high_mark,
  output logic              temp_live
);

  // controller to datapath commands and datapath status
  dea_cmd_t  cmd;
  dea_stat_t stat;

  // request sequencing and result handshake
  dea_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // counters, temp block state and result word
  dea_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req_type  (req_type),
    .req_size  (req_size),
    .req_mark  (req_mark),
    .cmd       (cmd),
    .stat      (stat),
    .status    (status),
    .address   (address),
    .low_mark  (low_mark),
    .high_mark (high_mark),
    .temp_live (temp_live)
  );

endmodule

[rtl/core/dea_ctrl.sv]
// sequencing state machine for the arena allocator
`timescale 1ns / 1ps

module dea_ctrl import dea_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  dea_stat_t stat,
  output dea_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RELEASE = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_RELEASE;
        end
      end
      S_RELEASE: begin
        cmd.rel = 1'b1;
        state_next = stat.alloc ? S_CHECK : S_COMMIT;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_to_release: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_RELEASE))
    else $error("accepted word did not enter release step");
  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");
  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");
  a_check_after_release: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> ($past(state) == S_RELEASE))
    else $error("check step entered out of order");
`endif

endmodule

[rtl/core/dea_dpath.sv]
// counters, fit check and result register for the arena allocator
`timescale 1ns / 1ps

module dea_dpath import dea_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_data,
  input  logic [2:0]        req_type,
  input  logic [ADDR_W-1:0] req_size,
  input  logic [ADDR_W-1:0] req_mark,
  input  dea_cmd_t          cmd,
  output dea_stat_t         stat,
  output logic [1:0]        status,
  output logic [ADDR_W-1:0] address,
  output logic [ADDR_W-1:0] low_mark,
  output logic [ADDR_W-1:0] high_mark,
  output logic              temp_live
);

  logic [ADDR_W-1:0] arena_size;
  logic [ADDR_W-1:0] low_used;
  logic [ADDR_W-1:0] high_used;
  logic              temp_active;
  logic [ADDR_W-1:0] temp_mark;

  logic [2:0]        op;
  logic [ADDR_W-1:0] mark;
  logic [NEED_W-1:0] need;
  logic              fit;
  logic [NEED_W-1:0] high_sum;

  logic [NEED_W-1:0] need_next;
  logic [SUM_W-1:0]  total;
  logic              releases;
  logic [ADDR_W-1:0] low_next;
  logic [ADDR_W-1:0] high_next;
  logic [1:0]        status_next;
  logic [ADDR_W-1:0] addr_next;

  // header plus size rounded up to 16
  assign need_next = NEED_W'(HEADER_BYTES)
                   + ((NEED_W'(req_size) + NEED_W'(ROUND_BYTES)) & ~NEED_W'(ROUND_BYTES));
  assign total = SUM_W'(low_used) + SUM_W'(high_used) + SUM_W'(need);

  assign releases = (op == REQ_ALLOC_HIGH) || (op == REQ_TEMP_ALLOC)
                 || (op == REQ_FREE_HIGH) || (op == REQ_READ_HIGH);
  assign stat.alloc = (op == REQ_ALLOC_LOW) || (op == REQ_ALLOC_HIGH)
                   || (op == REQ_TEMP_ALLOC);

  always_comb begin
    low_next = low_used;
    high_next = high_used;
    status_next = ST_OK;
    addr_next = '0;
    unique case (op)
      REQ_ALLOC_LOW: begin
        if (fit) begin
          addr_next = low_used + ADDR_W'(HEADER_BYTES);
          low_next = low_used + need[ADDR_W-1:0];
        end else begin
          status_next = ST_NO_SPACE;
        end
      end
      REQ_ALLOC_HIGH, REQ_TEMP_ALLOC: begin
        if (fit) begin
          high_next = high_sum[ADDR_W-1:0];
          addr_next = arena_size - high_sum[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
        end else begin
          status_next = ST_NO_SPACE;
        end
      end
      REQ_FREE_LOW: begin
        if (mark > low_used) status_next = ST_BAD_MARK;
        else low_next = mark;
      end
      REQ_FREE_HIGH: begin
        if (mark > high_used) status_next = ST_BAD_MARK;
        else high_next = mark;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_size <= ARENA_RESET;
      low_used <= '0;
      high_used <= '0;
      temp_active <= 1'b0;
      temp_mark <= '0;
    end else begin
      if (cfg_we) arena_size <= cfg_data;
      // temp release ahead of the high-side requests
      if (cmd.rel && releases && temp_active) begin
        temp_active <= 1'b0;
        if (temp_mark <= high_used) high_used <= temp_mark;
      end
      // a temp allocation records its mark even when it fails
      if (cmd.check && (op == REQ_TEMP_ALLOC)) begin
        temp_mark <= high_used;
        temp_active <= 1'b1;
      end
      if (cmd.commit) begin
        low_used <= low_next;
        high_used <= high_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= req_type;
      mark <= req_mark;
      need <= need_next;
    end
    if (cmd.check) begin
      fit <= (total <= SUM_W'(arena_size));
      high_sum <= NEED_W'(high_used) + need;
    end
    if (cmd.commit) begin
      status <= status_next;
      address <= addr_next;
      low_mark <= low_next;
      high_mark <= high_next;
      temp_live <= temp_active;
    end
  end

endmodule

[verif/testbench.sv]
// self-checking testbench for the double-ended arena allocator
`timescale 1ns / 1ps

module testbench;
  import dea_pkg::*;

  // the one request code the package leaves unnamed; it must be a no-op
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0]        kind;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] mark;
  } request_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] low;
    logic [ADDR_W-1:0] high;
    logic              temp;
  } outcome_t;

  // dut ports; the inputs are known from time zero
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        req_type = '0;
  logic [ADDR_W-1:0] req_size = '0;
  logic [ADDR_W-1:0] req_mark = '0;
  logic              out_valid;
  logic              out_stall = 1'b1;
  logic [1:0]        status;
  logic [ADDR_W-1:0] address;
  logic [ADDR_W-1:0] low_mark;
  logic [ADDR_W-1:0] high_mark;
  logic              temp_live;

  // requests waiting to be sent, and allocator outcomes still owed by the dut
  request_t request_queue[$];
  outcome_t owed_outcomes[$];
  int unsigned errors = 0;

  // shadow allocator state, kept in step with every accepted word
  logic [ADDR_W-1:0] arena_bytes = ARENA_RESET;
  logic [ADDR_W-1:0] low_bytes = '0;
  logic [ADDR_W-1:0] high_bytes = '0;
  logic              temp_on = 1'b0;
  logic [ADDR_W-1:0] temp_base = '0;

  // gap counters and burst flags for both sides
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  bit          send_burst = 1'b0;
  bit          take_burst = 1'b0;

  double_ended_arena_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .req_size  (req_size),
    .req_mark  (req_mark),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .address   (address),
    .low_mark  (low_mark),
    .high_mark (high_mark),
    .temp_live (temp_live)
  );

  always #5 clk = ~clk;

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  // a live temp block goes away: high end falls back to where it stood
  function automatic void drop_temp();
    if (temp_on) begin
      temp_on = 1'b0;
      if (temp_base <= high_bytes) high_bytes = temp_base;
    end
  endfunction

  // header plus payload rounded up to 16; can reach 2^24 + 16
  function automatic logic [31:0] block_need(input logic [ADDR_W-1:0] size);
    return 32'(HEADER_BYTES) + ((32'(size) + 32'(ROUND_BYTES)) & ~32'(ROUND_BYTES));
  endfunction

  function automatic bit room_for(input logic [31:0] need);
    return (32'(low_bytes) + 32'(high_bytes) + need) <= 32'(arena_bytes);
  endfunction

  // high end grows down; returns the status, address through addr
  function automatic logic [1:0] carve_high(input logic [ADDR_W-1:0] size,
                                            output logic [ADDR_W-1:0] addr);
    logic [31:0] need;
    need = block_need(size);
    addr = '0;
    if (!room_for(need)) return ST_NO_SPACE;
    high_bytes = ADDR_W'(32'(high_bytes) + need);
    addr = ADDR_W'(32'(arena_bytes) - 32'(high_bytes) + 32'(HEADER_BYTES));
    return ST_OK;
  endfunction

  // apply one request to the shadow state and return what the dut must answer
  function automatic outcome_t apply_request(input request_t rq);
    outcome_t    res;
    logic [31:0] need;
    res = '0;
    case (rq.kind)
      REQ_ALLOC_LOW: begin
        // low side leaves any temp block alone
        need = block_need(rq.size);
        if (!room_for(need)) begin
          res.status = ST_NO_SPACE;
        end else begin
          res.addr = ADDR_W'(32'(low_bytes) + 32'(HEADER_BYTES));
          low_bytes = ADDR_W'(32'(low_bytes) + need);
        end
      end
      REQ_ALLOC_HIGH: begin
        drop_temp();
        res.status = carve_high(rq.size, res.addr);
      end
      REQ_TEMP_ALLOC: begin
        // flag goes up even when the allocation itself fails
        drop_temp();
        temp_base = high_bytes;
        res.status = carve_high(rq.size, res.addr);
        temp_on = 1'b1;
      end
      REQ_FREE_LOW: begin
        if (rq.mark > low_bytes) res.status = ST_BAD_MARK;
        else low_bytes = rq.mark;
      end
      REQ_FREE_HIGH: begin
        drop_temp();
        if (rq.mark > high_bytes) res.status = ST_BAD_MARK;
        else high_bytes = rq.mark;
      end
      REQ_READ_HIGH: begin
        drop_temp();
      end
      default: begin
        // low read and the unused code only report the marks
      end
    endcase
    res.low = low_bytes;
    res.high = high_bytes;
    res.temp = temp_on;
    return res;
  endfunction

  // mostly back to back, some short pauses, a few long ones
  function automatic int unsigned next_gap(input bit burst);
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic request_t make_req(input logic [2:0] kind,
                                        input logic [ADDR_W-1:0] size,
                                        input logic [ADDR_W-1:0] mark);
    request_t rq;
    rq.kind = kind;
    rq.size = size;
    rq.mark = mark;
    return rq;
  endfunction

  // random request shaped by the current shadow state so frees mostly land
  function automatic request_t random_request();
    request_t    rq;
    int unsigned r;
    rq.size = ADDR_W'($urandom());
    rq.mark = ADDR_W'($urandom());
    r = $urandom_range(0, 99);
    if (r < 22) rq.kind = REQ_ALLOC_LOW;
    else if (r < 40) rq.kind = REQ_ALLOC_HIGH;
    else if (r < 55) rq.kind = REQ_TEMP_ALLOC;
    else if (r < 67) rq.kind = REQ_FREE_LOW;
    else if (r < 79) rq.kind = REQ_FREE_HIGH;
    else if (r < 87) rq.kind = REQ_READ_LOW;
    else if (r < 95) rq.kind = REQ_READ_HIGH;
    else rq.kind = REQ_UNUSED;

    // sizes: mostly a slice of the arena, some tiny, some extreme, some raw
    r = $urandom_range(0, 99);
    if (r < 50) rq.size = ADDR_W'($urandom_range(0, (arena_bytes >> 4) + 32));
    else if (r < 65) rq.size = ADDR_W'($urandom_range(0, 64));
    else if (r < 80) rq.size = ($urandom_range(0, 1) != 0) ? '1 : '0;

    // marks: mostly within current use, some just beyond it
    r = $urandom_range(0, 99);
    if (rq.kind == REQ_FREE_LOW || rq.kind == REQ_FREE_HIGH) begin
      if (r < 80) begin
        rq.mark = (rq.kind == REQ_FREE_LOW) ? ADDR_W'($urandom_range(0, low_bytes))
                                            : ADDR_W'($urandom_range(0, high_bytes));
      end else if (r < 92) begin
        rq.mark = ((rq.kind == REQ_FREE_LOW) ? low_bytes : high_bytes)
                  + ADDR_W'($urandom_range(1, 64));
      end
    end
    return rq;
  endfunction

  // request driver: holds a stalled word, predicts each accepted one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall)
        owed_outcomes.push_back(apply_request(make_req(req_type, req_size, req_mark)));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          request_t rq;
          rq = request_queue.pop_front();
          req_type <= rq.kind;
          req_size <= rq.size;
          req_mark <= rq.mark;
          in_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_gap = next_gap(send_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and stall generator
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b1;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_outcomes.size() == 0) begin
          report($sformatf("result word with nothing expected (status %0d addr %0h)",
                           status, address));
        end else begin
          outcome_t want;
          want = owed_outcomes.pop_front();
          if (status !== want.status)
            report($sformatf("status got %0d want %0d", status, want.status));
          if (address !== want.addr)
            report($sformatf("address got %0h want %0h", address, want.addr));
          if (low_mark !== want.low)
            report($sformatf("low_mark got %0h want %0h", low_mark, want.low));
          if (high_mark !== want.high)
            report($sformatf("high_mark got %0h want %0h", high_mark, want.high));
          if (temp_live !== want.temp)
            report($sformatf("temp_live got %0b want %0b", temp_live, want.temp));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
        stall_left = next_gap(take_burst);
      end
    end
  end

  // idle means nothing queued, nothing on the wire, nothing owed
  task automatic wait_idle();
    while (request_queue.size() != 0 || in_valid || owed_outcomes.size() != 0)
      @(posedge clk);
  endtask

  // refill in small batches so marks track the shadow state closely
  task automatic run_random(input int unsigned count);
    int unsigned left;
    int unsigned n;
    left = count;
    while (left > 0) begin
      @(negedge clk);
      if (request_queue.size() == 0) begin
        n = (left < 16) ? left : 16;
        repeat (n) request_queue.push_back(random_request());
        left -= n;
      end
    end
  endtask

  // arena change only while idle, after the pipeline has fully drained
  task automatic set_arena(input logic [ADDR_W-1:0] bytes);
    wait_idle();
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= bytes;
    arena_bytes = bytes;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [ADDR_W-1:0] arena_plan[7];
    int unsigned       phase_len[7];
    arena_plan = '{24'hFFFFFF, 24'd0, 24'd4096, 24'd40, 24'h000400,
                   ADDR_W'($urandom()), 24'h800000};
    phase_len = '{200, 60, 200, 100, 200, 200, 200};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed walk on the reset arena: rounding, limits, temp lifecycle
    @(negedge clk);
    request_queue.push_back(make_req(REQ_READ_LOW, '1, '1));
    request_queue.push_back(make_req(REQ_READ_HIGH, '1, '1));
    request_queue.push_back(make_req(REQ_ALLOC_LOW, 24'd0, '1));
    request_queue.push_back(make_req(REQ_ALLOC_LOW, 24'd1, '0));
    request_queue.push_back(make_req(REQ_ALLOC_LOW, 24'd16, '0));
    request_queue.push_back(make_req(REQ_ALLOC_LOW, 24'd17, '0));
    request_queue.push_back(make_req(REQ_ALLOC_LOW, '1, '0));
    request_queue.push_back(make_req(REQ_ALLOC_HIGH, 24'd0, '1));
    // temp block survives low-side traffic and a low read
    request_queue.push_back(make_req(REQ_TEMP_ALLOC, 24'd100, '0));
    request_queue.push_back(make_req(REQ_ALLOC_LOW, 24'd0, '0));
    request_queue.push_back(make_req(REQ_READ_LOW, '0, '0));
    request_queue.push_back(make_req(REQ_READ_HIGH, '0, '0));
    // failed temp still leaves the flag set, next high alloc clears it
    request_queue.push_back(make_req(REQ_TEMP_ALLOC, '1, '0));
    request_queue.push_back(make_req(REQ_ALLOC_HIGH, 24'd32, '0));
    request_queue.push_back(make_req(REQ_TEMP_ALLOC, 24'd8, '0));
    request_queue.push_back(make_req(REQ_FREE_HIGH, '0, '1));
    request_queue.push_back(make_req(REQ_TEMP_ALLOC, 24'd8, '0));
    request_queue.push_back(make_req(REQ_TEMP_ALLOC, 24'd8, '0));
    request_queue.push_back(make_req(REQ_FREE_HIGH, '1, '0));
    request_queue.push_back(make_req(REQ_FREE_LOW, '0, '1));
    request_queue.push_back(make_req(REQ_FREE_LOW, '1, 24'd48));
    request_queue.push_back(make_req(REQ_UNUSED, '1, '1));
    // exact fit of what is left, then a low alloc into a full arena
    request_queue.push_back(make_req(REQ_ALLOC_HIGH, 24'd8388544, '0));
    request_queue.push_back(make_req(REQ_ALLOC_LOW, 24'd0, '0));
    request_queue.push_back(make_req(REQ_FREE_LOW, '0, '0));

    run_random(200);

    // arena sweep: max, empty, small, shrunk below use, 1 KiB, random, default
    for (int i = 0; i < 7; i++) begin
      set_arena(arena_plan[i]);
      run_random(phase_len[i]);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
